// ----- src/prad_pkg.sv -----
// prad_pkg: shared types, constants and codes of the pixel radiance accumulator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package prad_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int FRAC_BITS  = 16;
   localparam int COUNT_BITS = 16;
   localparam int SUM_BITS   = 40;
   localparam int AVG_BITS   = 8 + FRAC_BITS;
   localparam int NPIX       = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS  = $clog2(NPIX);
   localparam int DIM_BITS   = 9;
   localparam int COORD_BITS = 8;
   localparam int STEP_BITS  = $clog2(AVG_BITS);
   localparam int REQ_BITS   = 152;
   localparam int RSP_BITS   = 96;

   // operation codes carried in req_tuser
   typedef enum logic [1:0] {
      KIND_ACC     = 2'd0,
      KIND_MERGE   = 2'd1,
      KIND_DEVELOP = 2'd2,
      KIND_CLEAR   = 2'd3
   } kind_type;

   // result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_SAT   = 2'd2;

   // configuration register indexes
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      S_CLR, S_IDLE, S_READ, S_EXEC, S_DIV, S_DONE
   } state_type;

   // one stored pixel
   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [SUM_BITS-1:0]   blue;
      logic [SUM_BITS-1:0]   green;
      logic [SUM_BITS-1:0]   red;
   } entry_type;

   // one result, red in the lowest bits
   typedef struct packed {
      logic [1:0]            status;
      logic                  empty;
      logic [COUNT_BITS-1:0] count;
      logic [AVG_BITS-1:0]   blue;
      logic [AVG_BITS-1:0]   green;
      logic [AVG_BITS-1:0]   red;
   } result_type;

   // lane status towards the merging stage
   typedef struct packed {
      logic busy;
      logic add_sat;
      logic avg_sat;
   } lane_stat_type;

endpackage

// ----- src/prad_store.sv -----
// prad_store: per-pixel sum and count memory, one write and one registered read port
// depends on prad_pkg
`timescale 1ns / 1ps

module prad_store import prad_pkg::*; (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  entry_type            wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output entry_type            rd_data
);

   entry_type mem_ff [NPIX];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/prad_lane.sv -----
// prad_lane: one colour channel, saturating sum update and rounding bit-serial divider
// depends on prad_pkg
`timescale 1ns / 1ps

module prad_lane import prad_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [SUM_BITS-1:0]   sum_old,
   input  logic [SUM_BITS-1:0]   sample,
   input  logic [COUNT_BITS-1:0] divisor,
   input  logic                  start,
   output logic [SUM_BITS-1:0]   sum_new,
   output logic [AVG_BITS-1:0]   avg,
   output lane_stat_type         stat
);

   logic [SUM_BITS:0]       add_full;
   logic [SUM_BITS:0]       dividend;
   logic [SUM_BITS:0]       limit;
   logic                    ovf;
   logic [COUNT_BITS:0]     trial;
   logic                    ge;
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [AVG_BITS-1:0]     quo_ff, quo_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;
   logic                    busy_ff, busy_in;
   logic                    asat_ff, asat_in;

   // saturating accumulate, the limit is all ones so a carry means overflow
   assign add_full = {1'b0, sum_old} + {1'b0, sample};
   assign sum_new  = add_full[SUM_BITS] ? {SUM_BITS{1'b1}} : add_full[SUM_BITS-1:0];

   // rounding bias and quotient range check
   assign dividend = {1'b0, sum_old} + (SUM_BITS+1)'(divisor >> 1);
   assign limit    = (SUM_BITS+1)'({divisor, {AVG_BITS{1'b0}}});
   assign ovf      = dividend >= limit;

   // one restoring step
   assign trial = {rem_ff, quo_ff[AVG_BITS-1]};
   assign ge    = trial >= {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      asat_in = asat_ff;
      if (start) begin
         step_in = '0;
         if (ovf) begin
            quo_in  = {AVG_BITS{1'b1}};
            asat_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = dividend[AVG_BITS+COUNT_BITS-1:AVG_BITS];
            quo_in  = dividend[AVG_BITS-1:0];
            asat_in = 1'b0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = ge ? COUNT_BITS'(trial - {1'b0, divisor}) : COUNT_BITS'(trial);
         quo_in  = {quo_ff[AVG_BITS-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(AVG_BITS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         asat_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         asat_ff <= asat_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign avg          = quo_ff;
   assign stat.busy    = busy_ff;
   assign stat.add_sat = add_full[SUM_BITS];
   assign stat.avg_sat = asat_ff;

endmodule

// ----- src/pixel_radiance_accumulator.sv -----
// pixel_radiance_accumulator: top level, sequencer, pixel store, three colour lanes
// depends on prad_pkg, prad_store, prad_lane
`timescale 1ns / 1ps

//  channel | ports            | direction | contents
//  request | req_t*           | in        | kind in tuser; x, y, r, g, b, count in tdata
//  result  | rsp_t*           | out       | r, g, b averages, count, empty, status
//  config  | csr_we/index/... | in        | image width (0), image height (1)
//
// accumulate and merge pass from acceptance to result through index, read, update, output.
// develop also runs the 24 one-bit steps of the lane dividers when the pixel is not empty.
// clear, and reset, sweep the 65536-entry store one entry a cycle; no request is taken then.
// a finished result waits in the output register while the next request is accepted.

module pixel_radiance_accumulator import prad_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // pixel_x[7:0], pixel_y[15:8], red_in[55:16], green_in[95:56], blue_in[135:96],
   // count_in[151:136]
   input  logic [REQ_BITS-1:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]          req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // red_avg[23:0], green_avg[47:24], blue_avg[71:48], pixel_count[87:72],
   // empty_pixel[88], status[90:89], zero[95:91]
   output logic [RSP_BITS-1:0] rsp_tdata,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [DIM_BITS-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [DIM_BITS-1:0]   width_ff, height_ff;
   logic [DIM_BITS-1:0]   w_use, h_use;

   kind_type              kind_ff;
   logic [COORD_BITS-1:0] x_ff, y_ff;
   logic [SUM_BITS-1:0]   r_ff, g_ff, b_ff;
   logic [COUNT_BITS-1:0] cin_ff;
   logic [ADDR_BITS-1:0]  idx_ff, idx_in;
   logic [ADDR_BITS-1:0]  ptr_ff;
   logic                  clr_item_ff;

   result_type            res_ff, res_in;
   result_type            rsp_ff;
   logic                  rsp_valid_ff;

   logic                  accept, in_range, out_free;
   logic [COORD_BITS-1:0] req_x, req_y;
   entry_type             rd_data, wr_data;
   logic                  wr_en, rd_en, lane_start;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [COUNT_BITS:0]   cnt_full;
   logic                  cnt_sat;
   logic [SUM_BITS-1:0]   sum_r, sum_g, sum_b;
   logic [AVG_BITS-1:0]   avg_r, avg_g, avg_b;
   lane_stat_type         st_r, st_g, st_b;

   // effective image size, zero counts as one and the maximum bounds it
   always_comb begin
      w_use = width_ff;
      h_use = height_ff;
      if (width_ff == '0) w_use = DIM_BITS'(1);
      else if (width_ff > DIM_BITS'(MAX_WIDTH)) w_use = DIM_BITS'(MAX_WIDTH);
      if (height_ff == '0) h_use = DIM_BITS'(1);
      else if (height_ff > DIM_BITS'(MAX_HEIGHT)) h_use = DIM_BITS'(MAX_HEIGHT);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_BITS'(256);
         height_ff <= DIM_BITS'(256);
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   assign req_x    = req_tdata[7:0];
   assign req_y    = req_tdata[15:8];
   assign in_range = ({1'b0, req_x} < w_use) && ({1'b0, req_y} < h_use);
   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // pixel index, row stride is the width in use
   assign idx_in = ADDR_BITS'(y_ff) * ADDR_BITS'(w_use) + ADDR_BITS'(x_ff);

   // count update
   assign cnt_full = {1'b0, rd_data.count}
                   + ((kind_ff == KIND_ACC) ? (COUNT_BITS+1)'(1) : {1'b0, cin_ff});
   assign cnt_sat  = cnt_full[COUNT_BITS];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLR: begin
            if (ptr_ff == {ADDR_BITS{1'b1}}) state_in = clr_item_ff ? S_DONE : S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               if (kind_type'(req_tuser) == KIND_CLEAR) state_in = S_CLR;
               else if (!in_range) state_in = S_DONE;
               else state_in = S_READ;
            end
         end
         S_READ: state_in = S_EXEC;
         S_EXEC: begin
            if (kind_ff == KIND_DEVELOP && rd_data.count != '0) state_in = S_DIV;
            else state_in = S_DONE;
         end
         S_DIV: begin
            if (!st_r.busy && !st_g.busy && !st_b.busy) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = '0;
      lane_start = 1'b0;
      case (state_ff)
         S_CLR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
         end
         S_IDLE: req_tready = 1'b1;
         S_READ: rd_en = 1'b1;
         S_EXEC: begin
            if (kind_ff == KIND_DEVELOP) begin
               lane_start = rd_data.count != '0;
            end else begin
               wr_en         = 1'b1;
               wr_data.red   = sum_r;
               wr_data.green = sum_g;
               wr_data.blue  = sum_b;
               wr_data.count = cnt_sat ? {COUNT_BITS{1'b1}} : cnt_full[COUNT_BITS-1:0];
            end
         end
         default: ;
      endcase
   end

   // merging stage: gathers the lane results into one result
   always_comb begin
      res_in = res_ff;
      case (state_ff)
         S_IDLE: begin
            res_in = '0;
            if (accept && kind_type'(req_tuser) != KIND_CLEAR && !in_range) begin
               res_in.status = STAT_RANGE;
            end
         end
         S_EXEC: begin
            if (kind_ff == KIND_DEVELOP) begin
               res_in.count = rd_data.count;
               res_in.empty = rd_data.count == '0;
            end else begin
               res_in.count  = cnt_sat ? {COUNT_BITS{1'b1}} : cnt_full[COUNT_BITS-1:0];
               res_in.status = (cnt_sat || st_r.add_sat || st_g.add_sat || st_b.add_sat)
                             ? STAT_SAT : STAT_OK;
            end
         end
         S_DIV: begin
            res_in.red    = avg_r;
            res_in.green  = avg_g;
            res_in.blue   = avg_b;
            res_in.status = (st_r.avg_sat || st_g.avg_sat || st_b.avg_sat)
                          ? STAT_SAT : STAT_OK;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         ptr_ff       <= '0;
         clr_item_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLR) ptr_ff <= ptr_ff + 1'b1;
         if (accept) clr_item_ff <= 1'b1;
         if (state_ff == S_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= kind_type'(req_tuser);
         x_ff    <= req_x;
         y_ff    <= req_y;
         r_ff    <= req_tdata[55:16];
         g_ff    <= req_tdata[95:56];
         b_ff    <= req_tdata[135:96];
         cin_ff  <= req_tdata[151:136];
      end
      if (state_ff == S_READ) idx_ff <= idx_in;
      res_ff <= res_in;
      if (state_ff == S_DONE && out_free) rsp_ff <= res_in;
   end

   prad_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   prad_lane u_lane_r (
      .clock   (clock),
      .reset   (reset),
      .sum_old (rd_data.red),
      .sample  (r_ff),
      .divisor (rd_data.count),
      .start   (lane_start),
      .sum_new (sum_r),
      .avg     (avg_r),
      .stat    (st_r)
   );

   prad_lane u_lane_g (
      .clock   (clock),
      .reset   (reset),
      .sum_old (rd_data.green),
      .sample  (g_ff),
      .divisor (rd_data.count),
      .start   (lane_start),
      .sum_new (sum_g),
      .avg     (avg_g),
      .stat    (st_g)
   );

   prad_lane u_lane_b (
      .clock   (clock),
      .reset   (reset),
      .sum_old (rd_data.blue),
      .sample  (b_ff),
      .divisor (rd_data.count),
      .start   (lane_start),
      .sum_new (sum_b),
      .avg     (avg_b),
      .stat    (st_b)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_BITS - $bits(result_type))'(0), rsp_ff};

endmodule

// ----- src/prad_checker.sv -----
// prad_checker: port-level checks of the pixel radiance accumulator, bound to the top level
// depends on prad_pkg and pixel_radiance_accumulator
`timescale 1ns / 1ps

module prad_checker import prad_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata
);

   // a held result keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // reset starts the clearing sweep with nothing to deliver
   assert property (@(posedge clock) reset |=> !rsp_tvalid && !req_tready)
      else $error("block not quiet after reset");

   // one transaction in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction taken while busy");

   // an out-of-range result carries nothing else
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[90:89] == STAT_RANGE |-> rsp_tdata[88:0] == '0)
      else $error("out-of-range result not zero");

   // an empty pixel develops to zero averages and zero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[88] |-> rsp_tdata[87:0] == '0 && rsp_tdata[90:89] == STAT_OK)
      else $error("empty pixel result malformed");

endmodule

bind pixel_radiance_accumulator prad_checker u_prad_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- bench/tb_pixel_radiance_accumulator.sv -----
// tb_pixel_radiance_accumulator: self-checking bench for the pixel radiance accumulator
// runs a directed table and then random phases against an own model of the pixel store
// depends on prad_pkg and pixel_radiance_accumulator
`timescale 1ns / 1ps

module tb_pixel_radiance_accumulator;
   import prad_pkg::*;

   localparam logic [SUM_BITS-1:0]   SUM_TOP = {SUM_BITS{1'b1}};
   localparam logic [AVG_BITS-1:0]   AVG_TOP = {AVG_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] CNT_TOP = {COUNT_BITS{1'b1}};
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE      = 40;

   // one pixel operation
   typedef struct {
      kind_type              kind;
      logic [7:0]            px;
      logic [7:0]            py;
      logic [SUM_BITS-1:0]   r;
      logic [SUM_BITS-1:0]   g;
      logic [SUM_BITS-1:0]   b;
      logic [COUNT_BITS-1:0] cnt;
   } pixel_op_type;

   // one developed result
   typedef struct {
      logic [AVG_BITS-1:0]   r;
      logic [AVG_BITS-1:0]   g;
      logic [AVG_BITS-1:0]   b;
      logic [COUNT_BITS-1:0] cnt;
      logic                  empty;
      logic [1:0]            status;
   } pixel_res_type;

   // directed row: optional resize before the operation, optional typed result
   typedef struct {
      logic          resize;
      logic [8:0]    new_w;
      logic [8:0]    new_h;
      pixel_op_type  op;
      logic          typed;
      pixel_res_type res;
   } dir_row_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata;
   logic [1:0]          req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic                csr_we;
   logic                csr_index;
   logic [DIM_BITS-1:0] csr_wdata;

   pixel_radiance_accumulator dut (.*);

   // model of the pixel store, absent entries read as zero
   logic [SUM_BITS-1:0]   red_store[int];
   logic [SUM_BITS-1:0]   green_store[int];
   logic [SUM_BITS-1:0]   blue_store[int];
   logic [COUNT_BITS-1:0] count_store[int];
   logic [8:0]            dim_w;
   logic [8:0]            dim_h;

   pixel_res_type pending_results[$];
   dir_row_type   dir_rows[$];
   int            mismatches;
   int            cycles;
   int            n_items;
   int            n_results;
   int            n_develop;
   int            n_sat;
   int            n_range;
   bit            long_hold;
   bit            no_idle;

   // clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_pixel_radiance_accumulator: FAIL");
         $finish;
      end
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      mismatches++;
      $display("mismatch on %s at result %0d: got %0h want %0h", what, n_results, got, want);
   endtask

   function automatic logic [8:0] eff_dim(input logic [8:0] v, input int top);
      if (v == 0) return 9'd1;
      if (v > top) return 9'(top);
      return v;
   endfunction

   function automatic logic [SUM_BITS-1:0] sat_sum(input logic [SUM_BITS-1:0] a,
                                                    input logic [SUM_BITS-1:0] b,
                                                    inout bit sat);
      logic [SUM_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[SUM_BITS]) begin
         sat = 1;
         return SUM_TOP;
      end
      return s[SUM_BITS-1:0];
   endfunction

   function automatic logic [AVG_BITS-1:0] box_average(input logic [SUM_BITS-1:0] sum,
                                                        input logic [COUNT_BITS-1:0] n,
                                                        inout bit sat);
      logic [63:0] q;
      q = (64'(sum) + 64'(n / 2)) / 64'(n);
      if (q > 64'(AVG_TOP)) begin
         sat = 1;
         return AVG_TOP;
      end
      return q[AVG_BITS-1:0];
   endfunction

   // apply one operation to the model store and work out its result
   function automatic pixel_res_type apply_pixel_op(input pixel_op_type op);
      pixel_res_type         res;
      logic [8:0]            w;
      logic [8:0]            h;
      int                    idx;
      bit                    sat;
      logic [SUM_BITS-1:0]   rs, gs, bs;
      logic [COUNT_BITS-1:0] cs;
      logic [16:0]           csum;
      res = '{default: '0};
      sat = 0;
      w = eff_dim(dim_w, MAX_WIDTH);
      h = eff_dim(dim_h, MAX_HEIGHT);
      if (op.kind == KIND_CLEAR) begin
         red_store.delete();
         green_store.delete();
         blue_store.delete();
         count_store.delete();
         return res;
      end
      if (op.px >= w || op.py >= h) begin
         res.status = STAT_RANGE;
         return res;
      end
      idx = int'(op.py) * int'(w) + int'(op.px);
      rs = red_store.exists(idx) ? red_store[idx] : '0;
      gs = green_store.exists(idx) ? green_store[idx] : '0;
      bs = blue_store.exists(idx) ? blue_store[idx] : '0;
      cs = count_store.exists(idx) ? count_store[idx] : '0;
      if (op.kind == KIND_DEVELOP) begin
         if (cs == 0) begin
            res.empty = 1'b1;
         end else begin
            res.r = box_average(rs, cs, sat);
            res.g = box_average(gs, cs, sat);
            res.b = box_average(bs, cs, sat);
         end
      end else begin
         rs = sat_sum(rs, op.r, sat);
         gs = sat_sum(gs, op.g, sat);
         bs = sat_sum(bs, op.b, sat);
         csum = {1'b0, cs} + ((op.kind == KIND_ACC) ? 17'd1 : {1'b0, op.cnt});
         if (csum[16]) begin
            sat = 1;
            cs = CNT_TOP;
         end else begin
            cs = csum[15:0];
         end
         red_store[idx] = rs;
         green_store[idx] = gs;
         blue_store[idx] = bs;
         count_store[idx] = cs;
      end
      res.cnt = cs;
      res.status = sat ? STAT_SAT : STAT_OK;
      return res;
   endfunction

   // send one transaction after a random gap, record its result at acceptance
   task automatic send_op(input pixel_op_type op, input bit typed,
                          input pixel_res_type typed_res);
      int            gap;
      pixel_res_type res;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op.kind;
      req_tdata  <= {op.cnt, op.b, op.g, op.r, op.py, op.px};
      do @(posedge clock); while (!req_tready);
      res = apply_pixel_op(op);
      pending_results.push_back(typed ? typed_res : res);
      n_items++;
      if (op.kind == KIND_DEVELOP) n_develop++;
   endtask

   // wait until every result is back and the block has settled
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_dims(input logic [8:0] w, input logic [8:0] h);
      csr_we    <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
      dim_w = w;
      dim_h = h;
   endtask

   task automatic add_row(input logic resize, input logic [8:0] w, input logic [8:0] h,
                          input kind_type k, input logic [7:0] x, input logic [7:0] y,
                          input logic [SUM_BITS-1:0] r, input logic [SUM_BITS-1:0] g,
                          input logic [SUM_BITS-1:0] b, input logic [COUNT_BITS-1:0] c,
                          input logic typed, input logic [AVG_BITS-1:0] avg,
                          input logic [COUNT_BITS-1:0] rc, input logic emp,
                          input logic [1:0] st);
      dir_row_type row;
      row.resize = resize;
      row.new_w  = w;
      row.new_h  = h;
      row.op     = '{k, x, y, r, g, b, c};
      row.typed  = typed;
      row.res    = '{avg, avg, avg, rc, emp, st};
      dir_rows.push_back(row);
   endtask

   function automatic pixel_op_type random_op(input bit allow_clear);
      pixel_op_type op;
      int           pick;
      logic [8:0]   w;
      logic [8:0]   h;
      w = eff_dim(dim_w, MAX_WIDTH);
      h = eff_dim(dim_h, MAX_HEIGHT);
      pick = $urandom_range(0, 99);
      if (allow_clear && pick == 0) op.kind = KIND_CLEAR;
      else if (pick < 50) op.kind = KIND_ACC;
      else if (pick < 65) op.kind = KIND_MERGE;
      else op.kind = KIND_DEVELOP;
      // mostly pixels in a small corner so they collect samples, some anywhere
      if ($urandom_range(0, 9) == 0) begin
         op.px = 8'($urandom_range(0, 255));
         op.py = 8'($urandom_range(0, 255));
      end else begin
         op.px = 8'($urandom_range(0, (w > 4 ? 4 : w - 1)));
         op.py = 8'($urandom_range(0, (h > 4 ? 4 : h - 1)));
      end
      if ($urandom_range(0, 7) == 0) begin
         op.r = {8'($urandom), $urandom};
         op.g = {8'($urandom), $urandom};
         op.b = {8'($urandom), $urandom};
      end else begin
         op.r = SUM_BITS'($urandom_range(0, 24'hFFFFFF));
         op.g = SUM_BITS'($urandom_range(0, 24'hFFFFFF));
         op.b = SUM_BITS'($urandom_range(0, 24'hFFFFFF));
      end
      op.cnt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
      return op;
   endfunction

   // result receiver with random back-pressure and one long hold
   initial begin
      int gap;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 6);
         if (long_hold) begin
            long_hold = 0;
            gap = 400;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // result checker
   always @(posedge clock) begin
      pixel_res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report("unexpected transaction", rsp_tdata[63:0], 64'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[23:0] !== want.r) report("red_avg", rsp_tdata[23:0], want.r);
            if (rsp_tdata[47:24] !== want.g) report("green_avg", rsp_tdata[47:24], want.g);
            if (rsp_tdata[71:48] !== want.b) report("blue_avg", rsp_tdata[71:48], want.b);
            if (rsp_tdata[87:72] !== want.cnt)
               report("pixel_count", rsp_tdata[87:72], want.cnt);
            if (rsp_tdata[88] !== want.empty) report("empty_pixel", rsp_tdata[88], want.empty);
            if (rsp_tdata[90:89] !== want.status)
               report("status", rsp_tdata[90:89], want.status);
            if (want.status == STAT_SAT) n_sat++;
            if (want.status == STAT_RANGE) n_range++;
         end
         n_results++;
      end
   end

   // main sequence
   initial begin
      logic [8:0]    phase_w[6];
      logic [8:0]    phase_h[6];
      int            per_phase[6];
      pixel_res_type none;
      none = '{default: '0};
      mismatches = 0;
      n_items = 0;
      n_results = 0;
      n_develop = 0;
      n_sat = 0;
      n_range = 0;
      long_hold = 0;
      no_idle = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= KIND_ACC;
      csr_we <= 1'b0;
      csr_index <= CSR_WIDTH;
      csr_wdata <= '0;
      dim_w = 9'd256;
      dim_h = 9'd256;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: extremes, saturation, rounding, empty pixel, clear, range
      add_row(0, 0, 0, KIND_DEVELOP, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1, STAT_OK);
      add_row(0, 0, 0, KIND_ACC, 255, 255, SUM_TOP, SUM_TOP, SUM_TOP, 0,
              1, 0, 1, 0, STAT_OK);
      add_row(0, 0, 0, KIND_ACC, 255, 255, SUM_TOP, SUM_TOP, SUM_TOP, CNT_TOP,
              1, 0, 2, 0, STAT_SAT);
      add_row(0, 0, 0, KIND_DEVELOP, 255, 255, 0, 0, 0, 0, 1, AVG_TOP, 2, 0, STAT_SAT);
      add_row(0, 0, 0, KIND_MERGE, 3, 4, 100, 200, 300, CNT_TOP, 1, 0, CNT_TOP, 0, STAT_OK);
      add_row(0, 0, 0, KIND_MERGE, 3, 4, 1, 1, 1, 1, 1, 0, CNT_TOP, 0, STAT_SAT);
      add_row(0, 0, 0, KIND_DEVELOP, 3, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, 0, KIND_ACC, 0, 0, 40'h10000, 40'h0, 40'hFFFFFF, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, 0, KIND_ACC, 0, 0, 40'h18000, 40'h1, 40'hFFFFFF, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, 0, KIND_DEVELOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, 0, KIND_MERGE, 0, 0, 40'h55AA55AA55, 40'hAA55AA55AA, 40'h7,
              0, 0, 0, 0, 0, 0);
      add_row(0, 0, 0, KIND_DEVELOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, 0, KIND_CLEAR, 9, 9, SUM_TOP, SUM_TOP, SUM_TOP, CNT_TOP,
              1, 0, 0, 0, STAT_OK);
      add_row(0, 0, 0, KIND_DEVELOP, 255, 255, 0, 0, 0, 0, 1, 0, 0, 1, STAT_OK);
      add_row(1, 5, 3, KIND_ACC, 5, 0, 1, 1, 1, 0, 1, 0, 0, 0, STAT_RANGE);
      add_row(0, 0, 0, KIND_DEVELOP, 0, 3, 0, 0, 0, 0, 1, 0, 0, 0, STAT_RANGE);
      add_row(0, 0, 0, KIND_MERGE, 255, 255, 5, 5, 5, 5, 1, 0, 0, 0, STAT_RANGE);
      add_row(0, 0, 0, KIND_ACC, 4, 2, 40'h123456, 40'h1, 40'hFFFF, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, 0, KIND_DEVELOP, 4, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(1, 0, 0, KIND_ACC, 0, 0, 40'h3, 40'h4, 40'h5, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, 0, KIND_ACC, 1, 0, 40'h3, 40'h4, 40'h5, 0, 1, 0, 0, 0, STAT_RANGE);
      add_row(0, 0, 0, KIND_DEVELOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].resize) begin
            drain();
            write_dims(dir_rows[i].new_w, dir_rows[i].new_h);
         end
         send_op(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].res);
      end

      // random phases across sizes, extremes and out-of-range register values among them
      phase_w = '{9'd1, 9'd256, 9'd16, 9'd511, 9'd7, 9'd300};
      phase_h = '{9'd1, 9'd256, 9'd16, 9'd300, 9'd200, 9'd0};
      per_phase = '{60, 80, 80, 80, 80, 70};
      for (int p = 0; p < 6; p++) begin
         drain();
         write_dims(phase_w[p], phase_h[p]);
         no_idle = (p == 2);
         if (p == 1) long_hold = 1;
         for (int n = 0; n < per_phase[p]; n++)
            send_op(random_op(p == 3 || p == 5), 0, none);
      end
      drain();

      $display("covered %0d transactions, %0d develops, %0d saturated, %0d out of range",
               n_items, n_develop, n_sat, n_range);
      $display("six random size phases plus a long result hold; %0d mismatches", mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("tb_pixel_radiance_accumulator: PASS");
      end else begin
         $display("tb_pixel_radiance_accumulator: FAIL");
      end
      $finish;
   end

endmodule
